[design/pcs_pkg.sv]
// Shared types, constants and pattern tables of the playlist content sniffer.
`timescale 1ns / 1ps

package pcs_pkg;

   // Bytes held for matching: the current byte plus the recent history
   localparam int unsigned WINDOW_BYTES = 29;
   localparam int unsigned RECENT_DEPTH = WINDOW_BYTES - 1;

   // Longest pattern; must not exceed WINDOW_BYTES
   localparam int unsigned PAT_MAX  = 29;
   localparam int unsigned PAT_BITS = 8 * PAT_MAX;

   localparam int unsigned SLOT_COUNT  = 6;
   localparam int unsigned BODY_COUNT  = 4;
   localparam int unsigned HEAD_COUNT  = 6;

   typedef logic [7:0]                byte_type;
   typedef logic [5:0]                pat_len_type;
   typedef logic [SLOT_COUNT-1:0]     slot_mask_type;
   typedef logic [PAT_BITS-1:0]       pat_bits_type;

   // Result codes
   typedef enum logic [1:0] {
      KIND_NONE = 2'd0,
      KIND_HLS  = 2'd1,
      KIND_M3U  = 2'd2,
      KIND_PLS  = 2'd3
   } kind_type;

   // Sniff mode codes
   typedef enum logic {
      MODE_BODY   = 1'b0,
      MODE_HEADER = 1'b1
   } mode_type;

   // Control from the request stage to the matcher
   typedef struct packed {
      logic fire;
      logic last;
   } pcs_step_type;

   // Patterns are lower case; last character sits in the lowest byte
   localparam pat_bits_type BODY_PATS [BODY_COUNT] = '{
      pat_bits_type'("#ext-x-"),
      pat_bits_type'("[playlist]"),
      pat_bits_type'("file1="),
      pat_bits_type'("#extm3u")
   };
   localparam pat_len_type BODY_LENS [BODY_COUNT] = '{
      6'd7, 6'd10, 6'd6, 6'd7
   };

   localparam pat_bits_type HEAD_PATS [HEAD_COUNT] = '{
      pat_bits_type'("application/vnd.apple.mpegurl"),
      pat_bits_type'("audio/x-scpls"),
      pat_bits_type'("application/pls"),
      pat_bits_type'("audio/mpegurl"),
      pat_bits_type'("audio/x-mpegurl"),
      pat_bits_type'("application/x-mpegurl")
   };
   localparam pat_len_type HEAD_LENS [HEAD_COUNT] = '{
      6'd29, 6'd13, 6'd15, 6'd13, 6'd15, 6'd21
   };

   // Fold ASCII upper case to lower case, leave every other value alone
   function automatic byte_type fold_case(input byte_type c);
      byte_type r;
      r = c;
      if (c >= 8'h41 && c <= 8'h5A) begin
         r = c + 8'h20;
      end
      return r;
   endfunction

   // Compare the tail of the window against one pattern
   function automatic logic pat_hit(input byte_type win [WINDOW_BYTES],
                                    input pat_bits_type pat,
                                    input pat_len_type len);
      logic hit;
      hit = 1'b1;
      for (int j = 0; j < PAT_MAX; j++) begin
         if (j < int'(len)) begin
            if (win[WINDOW_BYTES-1-j] != pat[8*j +: 8]) begin
               hit = 1'b0;
            end
         end
      end
      return hit;
   endfunction

endpackage

[design/pcs_match.sv]
// Sliding byte window, pattern compare, sticky seen flags and kind decision.
`timescale 1ns / 1ps

module pcs_match
   import pcs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  pcs_step_type step,
   input  byte_type     cur_byte,
   input  logic         csr_write,
   input  logic         csr_mode,
   output kind_type     kind
);

   byte_type      recent_ff [RECENT_DEPTH];
   byte_type      recent_in [RECENT_DEPTH];
   slot_mask_type seen_ff;
   slot_mask_type seen_in;
   mode_type      mode_ff;
   mode_type      mode_in;

   byte_type      win [WINDOW_BYTES];
   slot_mask_type hits;
   slot_mask_type seen_now;

   // Assemble the window: history then the current byte
   always_comb begin
      for (int k = 0; k < RECENT_DEPTH; k++) begin
         win[k] = recent_ff[k];
      end
      win[WINDOW_BYTES-1] = cur_byte;
   end

   // Compare every pattern of the active mode in parallel
   always_comb begin
      hits = '0;
      if (mode_ff == MODE_HEADER) begin
         for (int s = 0; s < HEAD_COUNT; s++) begin
            hits[s] = pat_hit(win, HEAD_PATS[s], HEAD_LENS[s]);
         end
      end else begin
         for (int s = 0; s < BODY_COUNT; s++) begin
            hits[s] = pat_hit(win, BODY_PATS[s], BODY_LENS[s]);
         end
      end
      seen_now = seen_ff | hits;
   end

   // Turn the flags into a kind by priority
   always_comb begin
      kind = KIND_NONE;
      if (mode_ff == MODE_HEADER) begin
         priority if (seen_now[0])                 kind = KIND_HLS;
         else if (seen_now[1] || seen_now[2])      kind = KIND_PLS;
         else if (seen_now[3] || seen_now[4] || seen_now[5]) kind = KIND_M3U;
         else                                      kind = KIND_NONE;
      end else begin
         priority if (seen_now[0])                 kind = KIND_HLS;
         else if (seen_now[1] && seen_now[2])      kind = KIND_PLS;
         else if (seen_now[3])                     kind = KIND_M3U;
         else                                      kind = KIND_NONE;
      end
   end

   // Next state: shift on each request, clear at end of text or mode write
   always_comb begin
      recent_in = recent_ff;
      seen_in   = seen_ff;
      mode_in   = mode_ff;
      if (csr_write) begin
         mode_in = mode_type'(csr_mode);
         seen_in = '0;
         for (int k = 0; k < RECENT_DEPTH; k++) begin
            recent_in[k] = '0;
         end
      end else if (step.fire) begin
         if (step.last) begin
            seen_in = '0;
            for (int k = 0; k < RECENT_DEPTH; k++) begin
               recent_in[k] = '0;
            end
         end else begin
            seen_in = seen_now;
            for (int k = 0; k < RECENT_DEPTH; k++) begin
               recent_in[k] = win[k+1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_BODY;
         seen_ff <= '0;
         for (int k = 0; k < RECENT_DEPTH; k++) begin
            recent_ff[k] <= '0;
         end
      end else begin
         mode_ff   <= mode_in;
         seen_ff   <= seen_in;
         recent_ff <= recent_in;
      end
   end

endmodule

[design/pcs_rsp_reg.sv]
// Result register holding one playlist kind until the consumer takes it.
`timescale 1ns / 1ps

module pcs_rsp_reg
   import pcs_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     load,
   input  kind_type kind,
   output logic     slot_free,
   output logic     rsp_tvalid,
   input  logic     rsp_tready,
   output logic [7:0] rsp_tdata   // [1:0] playlist_kind, [7:2] zero
);

   logic     vld_ff;
   logic     vld_in;
   kind_type kind_ff;

   assign slot_free = !vld_ff || rsp_tready;

   // Hold the result until taken, load a new one when the slot frees
   assign vld_in = load || (vld_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff <= kind;
      end
   end

   assign rsp_tvalid = vld_ff;
   assign rsp_tdata  = {6'b0, kind_ff};

endmodule

[design/playlist_content_sniffer_top.sv]
// Top level of the playlist content sniffer: request register, matcher, result register.
// rsp_tvalid rises once a tlast request moves from the request to the result register.
// Throughput: one byte per cycle; the request register drains while a result waits,
// and stalls only when a last byte meets a result that is still untaken.
// Reset: clears the request and result valids, the byte window, the seen flags,
// and sets body mode.
`timescale 1ns / 1ps

module playlist_content_sniffer_top
   import pcs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] text_byte
   input  logic       req_tlast,   // last_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [1:0] playlist_kind, [7:2] zero
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_data     // sniff_mode
);

   logic         in_vld_ff;
   logic         in_vld_in;
   byte_type     in_byte_ff;
   logic         in_last_ff;
   logic         slot_free;
   logic         proc_fire;
   pcs_step_type step;
   kind_type     kind;

   // Process the held byte unless it is a last byte facing a full result slot
   assign proc_fire  = in_vld_ff && (!in_last_ff || slot_free);
   assign req_tready = !in_vld_ff || proc_fire;
   assign csr_ready  = !in_vld_ff;

   assign in_vld_in = (req_tvalid && req_tready) || (in_vld_ff && !proc_fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   // Capture the request with case already folded
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= fold_case(req_tdata);
         in_last_ff <= req_tlast;
      end
   end

   assign step.fire = proc_fire;
   assign step.last = in_last_ff;

   pcs_match u_match (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .cur_byte  (in_byte_ff),
      .csr_write (csr_valid && csr_ready),
      .csr_mode  (csr_data),
      .kind      (kind)
   );

   pcs_rsp_reg u_rsp (
      .clock      (clock),
      .reset      (reset),
      .load       (proc_fire && in_last_ff),
      .kind       (kind),
      .slot_free  (slot_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

[design/pcs_checker.sv]
// Port-level checker for the playlist content sniffer, bound to the top level.
`timescale 1ns / 1ps

module pcs_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       req_tlast,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata
);

   // A stalled result holds its value
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // Upper result bits stay zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[7:2] == 6'b0)
      else $error("result padding not zero");

   // No result right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // A fresh result follows a taken last byte
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready && req_tlast, 2))
      else $error("result without a last request");

endmodule

bind playlist_content_sniffer_top pcs_checker u_pcs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
